// ----- hdl/hsv_to_rgb_percent_assert.svh -----
// assertion macros shared by the hsv to rgb checker
`ifndef HSV_TO_RGB_PERCENT_ASSERT_SVH
`define HSV_TO_RGB_PERCENT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_percent check failed");

// next-cycle implication, disabled while reset is low
`define HSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_percent check failed");

`endif

// ----- hdl/hsvrgb_pkg.sv -----
// shared types and constants of the hsv to rgb converter
`default_nettype none

package hsvrgb_pkg;

    localparam logic [6:0]  PCT_FULL     = 7'd100;
    // x / 100 as (x * 5243) >> 19, exact for x up to 25500
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_R_Y = 3'd0;
    localparam t_sector SEC_Y_G = 3'd1;
    localparam t_sector SEC_G_C = 3'd2;
    localparam t_sector SEC_C_B = 3'd3;
    localparam t_sector SEC_B_M = 3'd4;
    localparam t_sector SEC_M_R = 3'd5;

    typedef struct packed {
        t_sector    sector;
        logic [6:0] frac;
        logic [6:0] sat;
        logic [6:0] val;
    } t_sect_item;

    typedef struct packed {
        t_sector    sector;
        logic [6:0] val;
        logic [6:0] p_lvl;
        logic [6:0] q_lvl;
        logic [6:0] t_lvl;
    } t_mix_item;

endpackage

`default_nettype wire

// ----- hdl/hsvrgb_sector.sv -----
// hue wrap, percent clamp, sector and fraction (two stages)
`default_nettype none

module hsvrgb_sector import hsvrgb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [8:0] i_hue,
    input  logic [6:0] i_sat,
    input  logic [6:0] i_val,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sect_item o_item
);

    localparam logic [8:0]  HueWrap   = 9'd360;
    localparam logic [8:0]  SectorDeg = 9'd60;
    // 5*rem/3 as (rem * 3415) >> 11, exact for rem below 60
    localparam logic [17:0] ThirdMul  = 18'd3415;

    logic       r_a_valid;
    logic [8:0] r_a_hue;
    logic [6:0] r_a_sat;
    logic [6:0] r_a_val;
    logic       r_b_valid;
    t_sect_item r_b_item;

    logic       en_a;
    logic       en_b;
    logic [8:0] n_hue;
    logic [6:0] n_sat;
    logic [6:0] n_val;
    t_sector    sector;
    logic [8:0] base;
    logic [8:0] rem_full;
    logic [17:0] frac_prod;

    assign en_b    = !r_b_valid || i_ready;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;

    assign n_hue = (i_hue >= HueWrap) ? (i_hue - HueWrap) : i_hue;
    assign n_sat = (i_sat > PCT_FULL) ? PCT_FULL : i_sat;
    assign n_val = (i_val > PCT_FULL) ? PCT_FULL : i_val;

    always_comb begin
        if (r_a_hue >= 9'(5 * SectorDeg)) begin
            sector = SEC_M_R;
            base   = 9'(5 * SectorDeg);
        end else if (r_a_hue >= 9'(4 * SectorDeg)) begin
            sector = SEC_B_M;
            base   = 9'(4 * SectorDeg);
        end else if (r_a_hue >= 9'(3 * SectorDeg)) begin
            sector = SEC_C_B;
            base   = 9'(3 * SectorDeg);
        end else if (r_a_hue >= 9'(2 * SectorDeg)) begin
            sector = SEC_G_C;
            base   = 9'(2 * SectorDeg);
        end else if (r_a_hue >= SectorDeg) begin
            sector = SEC_Y_G;
            base   = SectorDeg;
        end else begin
            sector = SEC_R_Y;
            base   = 9'd0;
        end
    end

    assign rem_full  = r_a_hue - base;
    assign frac_prod = 18'(rem_full[5:0]) * ThirdMul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_a_hue <= n_hue;
            r_a_sat <= n_sat;
            r_a_val <= n_val;
        end
        if (en_b && r_a_valid) begin
            r_b_item.sector <= sector;
            r_b_item.frac   <= frac_prod[17:11];
            r_b_item.sat    <= r_a_sat;
            r_b_item.val    <= r_a_val;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

`default_nettype wire

// ----- hdl/hsvrgb_mix.sv -----
// p, q and t levels: products, scaled products, reciprocal divide (three stages)
`default_nettype none

module hsvrgb_mix import hsvrgb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_sect_item i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_mix_item  o_item
);

    localparam logic [13:0] PctSq       = 14'd10000;
    // x / 10000 as (x * 429497) >> 32, exact for x up to 1000000
    localparam logic [38:0] Div10kMul   = 39'd429497;
    localparam int unsigned Div10kShift = 32;

    logic        r_c_valid;
    t_sector     r_c_sector;
    logic [6:0]  r_c_val;
    logic [13:0] r_c_qa;
    logic [13:0] r_c_ta;
    logic [13:0] r_c_pn;

    logic        r_d_valid;
    t_sector     r_d_sector;
    logic [6:0]  r_d_val;
    logic [19:0] r_d_qn;
    logic [19:0] r_d_tn;
    logic [13:0] r_d_pn;

    logic        r_e_valid;
    t_mix_item   r_e_item;

    logic        en_c;
    logic        en_d;
    logic        en_e;
    logic [13:0] fs;
    logic [13:0] sc;
    logic [13:0] pn;
    logic [26:0] p_prod;
    logic [38:0] q_prod;
    logic [38:0] t_prod;

    assign en_e    = !r_e_valid || i_ready;
    assign en_d    = !r_d_valid || en_e;
    assign en_c    = !r_c_valid || en_d;
    assign o_ready = en_c;

    assign fs = 14'(i_item.frac) * 14'(i_item.sat);
    assign sc = 14'(i_item.sat) * 14'(PCT_FULL - i_item.frac);
    assign pn = 14'(i_item.val) * 14'(PCT_FULL - i_item.sat);

    assign p_prod = 27'(r_d_pn) * 27'(DIV100_MUL);
    assign q_prod = 39'(r_d_qn) * Div10kMul;
    assign t_prod = 39'(r_d_tn) * Div10kMul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (en_c) begin
                r_c_valid <= i_valid;
            end
            if (en_d) begin
                r_d_valid <= r_c_valid;
            end
            if (en_e) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && i_valid) begin
            r_c_sector <= i_item.sector;
            r_c_val    <= i_item.val;
            r_c_qa     <= PctSq - fs;
            r_c_ta     <= PctSq - sc;
            r_c_pn     <= pn;
        end
        if (en_d && r_c_valid) begin
            r_d_sector <= r_c_sector;
            r_d_val    <= r_c_val;
            r_d_qn     <= 20'(r_c_val) * 20'(r_c_qa);
            r_d_tn     <= 20'(r_c_val) * 20'(r_c_ta);
            r_d_pn     <= r_c_pn;
        end
        if (en_e && r_d_valid) begin
            r_e_item.sector <= r_d_sector;
            r_e_item.val    <= r_d_val;
            r_e_item.p_lvl  <= p_prod[DIV100_SHIFT +: 7];
            r_e_item.q_lvl  <= q_prod[Div10kShift +: 7];
            r_e_item.t_lvl  <= t_prod[Div10kShift +: 7];
        end
    end

    assign o_valid = r_e_valid;
    assign o_item  = r_e_item;

endmodule

`default_nettype wire

// ----- hdl/hsvrgb_out.sv -----
// sector select, scale to 8-bit levels, rgb565 pack and output register
`default_nettype none

module hsvrgb_out import hsvrgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_mix_item   i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [15:0] o_packed
);

    // percent level (0..100) to 0..255, truncating
    function automatic logic [7:0] to_level(input logic [6:0] pct);
        logic [14:0] x255;
        logic [27:0] prod;
        x255 = {pct, 8'b0} - 15'(pct);
        prod = 28'(x255) * 28'(DIV100_MUL);
        return prod[DIV100_SHIFT +: 8];
    endfunction

    logic        r_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [15:0] r_packed;

    logic       en;
    logic [6:0] red_pct;
    logic [6:0] green_pct;
    logic [6:0] blue_pct;
    logic [7:0] n_red;
    logic [7:0] n_green;
    logic [7:0] n_blue;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        case (i_item.sector)
            SEC_R_Y: begin
                red_pct = i_item.val;   green_pct = i_item.t_lvl; blue_pct = i_item.p_lvl;
            end
            SEC_Y_G: begin
                red_pct = i_item.q_lvl; green_pct = i_item.val;   blue_pct = i_item.p_lvl;
            end
            SEC_G_C: begin
                red_pct = i_item.p_lvl; green_pct = i_item.val;   blue_pct = i_item.t_lvl;
            end
            SEC_C_B: begin
                red_pct = i_item.p_lvl; green_pct = i_item.q_lvl; blue_pct = i_item.val;
            end
            SEC_B_M: begin
                red_pct = i_item.t_lvl; green_pct = i_item.p_lvl; blue_pct = i_item.val;
            end
            SEC_M_R: begin
                red_pct = i_item.val;   green_pct = i_item.p_lvl; blue_pct = i_item.q_lvl;
            end
            default: begin
                red_pct = i_item.val;   green_pct = i_item.p_lvl; blue_pct = i_item.q_lvl;
            end
        endcase
    end

    assign n_red   = to_level(red_pct);
    assign n_green = to_level(green_pct);
    assign n_blue  = to_level(blue_pct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_packed <= {n_red[7:3], n_green[7:2], n_blue[7:3]};
        end
    end

    assign o_valid  = r_valid;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_packed = r_packed;

endmodule

`default_nettype wire

// ----- hdl/hsv_to_rgb_percent.sv -----
// hsv to rgb converter top level: percent saturation/value, degree hue
//
// input stream (s_axis): one item is a hue in degrees with saturation and value in
// percent; hue of 360 or more wraps modulo 360, percents above 100 clamp to 100
// output stream (m_axis): one item per input item, in order: 8-bit red, green and
// blue levels and the same color packed as an rgb565 word
// throughput: one item per cycle while i_m_axis_tready is high; six register
// stages, each with its own valid bit, and each stage loads when it is empty or
// the stage after it moves on
// stages: hue wrap and clamp | sector and fraction | p/q/t numerators |
//   v-scaled products | reciprocal divides | channel select, scale, output register
// stall: when i_m_axis_tready is low the result holds in the output register and
// items keep entering until the bubbles ahead of them are filled; nothing is
// dropped or repeated
// reset: synchronous, active low; clears all valid bits, payload is not reset
// no configuration registers and no state carried from item to item
`default_nettype none

module hsv_to_rgb_percent import hsvrgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // hue_degrees[8:0], saturation_pct[15:9], value_pct[22:16], zero pad [23]
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // red_level[7:0], green_level[15:8], blue_level[23:16], packed_565[39:24]
    output logic [39:0] o_m_axis_tdata
);

    // sector stage to mix stage
    logic       sect_valid;
    logic       sect_ready;
    t_sect_item sect_item;

    // mix stage to output stage
    logic       mix_valid;
    logic       mix_ready;
    t_mix_item  mix_item;

    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [15:0] packed_565;

    // wrap, clamp, then split hue into a 60 degree sector and 0..98 fraction
    hsvrgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[8:0]),
        .i_sat   (i_s_axis_tdata[15:9]),
        .i_val   (i_s_axis_tdata[22:16]),
        .o_valid (sect_valid),
        .i_ready (sect_ready),
        .o_item  (sect_item)
    );

    // p, q, t percent levels with truncating divides by 100 and 10000
    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sect_valid),
        .o_ready (sect_ready),
        .i_item  (sect_item),
        .o_valid (mix_valid),
        .i_ready (mix_ready),
        .o_item  (mix_item)
    );

    // six-way channel select, scale by 255/100, rgb565 pack
    hsvrgb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mix_valid),
        .o_ready  (mix_ready),
        .i_item   (mix_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_red    (red_level),
        .o_green  (green_level),
        .o_blue   (blue_level),
        .o_packed (packed_565)
    );

    assign o_m_axis_tdata = {packed_565, blue_level, green_level, red_level};

endmodule

`default_nettype wire

// ----- hdl/hsv_to_rgb_percent_chk.sv -----
// port-level checker for the hsv to rgb converter, with its bind
`default_nettype none

`include "hsv_to_rgb_percent_assert.svh"

module hsv_to_rgb_percent_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    localparam logic [2:0] Depth = 3'd6;

    logic       in_acc;
    logic       out_acc;
    logic       pack_ok;
    logic [2:0] r_inflight;
    logic [2:0] n_inflight;

    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc    = o_m_axis_tvalid && i_m_axis_tready;
    assign n_inflight = r_inflight + 3'(in_acc) - 3'(out_acc);

    // rgb565 fields against the top bits of the 8-bit levels
    assign pack_ok = (o_m_axis_tdata[39:35] == o_m_axis_tdata[7:3])
                  && (o_m_axis_tdata[34:29] == o_m_axis_tdata[15:10])
                  && (o_m_axis_tdata[28:24] == o_m_axis_tdata[23:19]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 3'd0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // a waiting result holds its value
    `HSV_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
                     o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // every result stems from an accepted item
    `HSV_ASSERT_IMP(a_no_orphan, i_clk, i_rst_n, o_m_axis_tvalid, r_inflight != 3'd0)
    // never more items inside than pipeline stages
    `HSV_ASSERT_IMP(a_depth, i_clk, i_rst_n, 1'b1, r_inflight <= Depth)
    // rgb565 word agrees with the 8-bit levels
    `HSV_ASSERT_IMP(a_pack, i_clk, i_rst_n, o_m_axis_tvalid, pack_ok)
    // a free output lets the whole pipeline move
    `HSV_ASSERT_IMP(a_flow, i_clk, i_rst_n, i_m_axis_tready, o_s_axis_tready)

endmodule

bind hsv_to_rgb_percent hsv_to_rgb_percent_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ----- bench/hsv_to_rgb_percent_checker.sv -----
`timescale 1ns / 1ps
// checker for the hsv to rgb converter: predicts each color and compares the output stream
module hsv_to_rgb_percent_checker import hsvrgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // hue_degrees[8:0], saturation_pct[15:9], value_pct[22:16], zero pad [23]
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // red_level[7:0], green_level[15:8], blue_level[23:16], packed_565[39:24]
    input  logic [39:0] i_m_tdata,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_checked
);

    // same layout as the output tdata, red in the lowest byte
    typedef struct packed {
        logic [15:0] rgb565;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_color;

    t_color color_queue[$];

    function automatic t_color predict_color(logic [8:0] hue, logic [6:0] sat_in,
                                             logic [6:0] val_in);
        int unsigned h, s, v, sec, frac, p, q, t, r, g, b;
        t_color c;
        h    = hue % 360;
        s    = (sat_in > PCT_FULL) ? PCT_FULL : sat_in;
        v    = (val_in > PCT_FULL) ? PCT_FULL : val_in;
        sec  = h / 60;
        frac = 100 * h / 60 - 100 * sec;
        p    = v * (100 - s) / 100;
        q    = v * (10000 - frac * s) / 10000;
        t    = v * (10000 - s * (100 - frac)) / 10000;
        case (t_sector'(sec))
            SEC_R_Y: begin r = v; g = t; b = p; end
            SEC_Y_G: begin r = q; g = v; b = p; end
            SEC_G_C: begin r = p; g = v; b = t; end
            SEC_C_B: begin r = p; g = q; b = v; end
            SEC_B_M: begin r = t; g = p; b = v; end
            // magenta to red
            default: begin r = v; g = p; b = q; end
        endcase
        c.red    = 8'(r * 255 / 100);
        c.green  = 8'(g * 255 / 100);
        c.blue   = 8'(b * 255 / 100);
        c.rgb565 = {c.red[7:3], c.green[7:2], c.blue[7:3]};
        return c;
    endfunction

    task automatic report_mismatch(string what, longint expected, longint got);
        $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, expected, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : check_proc
        t_color want;
        t_color got;
        if (!i_rst_n) begin
            color_queue.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_pending   <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (color_queue.size() == 0) begin
                    report_mismatch("result with no item pending", 0, i_m_tdata);
                end else begin
                    want = color_queue.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("red_level", want.red, got.red);
                    if (got.green !== want.green)
                        report_mismatch("green_level", want.green, got.green);
                    if (got.blue !== want.blue)
                        report_mismatch("blue_level", want.blue, got.blue);
                    if (got.rgb565 !== want.rgb565)
                        report_mismatch("packed_565", want.rgb565, got.rgb565);
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                color_queue.push_back(predict_color(i_s_tdata[8:0], i_s_tdata[15:9],
                                                    i_s_tdata[22:16]));
            o_pending <= color_queue.size();
        end
    end

endmodule

// ----- bench/tb_hsv_to_rgb_percent.sv -----
`timescale 1ns / 1ps
// testbench top for the hsv to rgb converter: stimulus, flow control and verdict
module tb_hsv_to_rgb_percent;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int HOLD_CYCLES    = 300;   // long output hold to back the pipe up
    localparam int DRAIN_CYCLES   = 12;    // idle tail after the last results have come back
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side
    localparam int N_DIRECTED     = 24;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // hue_degrees[8:0], saturation_pct[15:9], value_pct[22:16], zero pad [23]
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // red_level[7:0], green_level[15:8], blue_level[23:16], packed_565[39:24]
    logic [39:0] m_tdata;

    int pending;
    int fail_count;
    int checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int items_sent    = 0;
    int idle_cycles   = 0;

    // directed corners: every sector edge, hue wrap, clamped and zero percents
    int dir_hue[N_DIRECTED] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359,
                                360, 419, 420, 511, 30, 90, 150, 210, 270, 330, 1, 255};
    int dir_sat[N_DIRECTED] = '{100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
                                100, 127, 101, 100, 0, 50, 99, 1, 127, 64, 100, 127};
    int dir_val[N_DIRECTED] = '{100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
                                100, 127, 101, 100, 100, 0, 99, 1, 127, 63, 50, 0};

    hsv_to_rgb_percent DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // watches both streams, predicts every color and counts mismatches
    hsv_to_rgb_percent_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure, plus a long hold whenever hold_req moves
    initial begin : sink_proc
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: any cycle where an item moves on either side restarts the count
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input logic [8:0] hue, input logic [6:0] sat,
                             input logic [6:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, sat, hue};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // stop offering items and wait until every predicted color has come back
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
    endtask

    // mostly in-range percents, a quarter over the full 7-bit range to hit the clamp
    function automatic logic [6:0] rand_pct();
        return ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
    endfunction

    initial begin : stim_proc
        int phase;
        int i;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 0: sender idles a little, receiver a lot; phase 1 swaps; phase 2 none
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 29 : 0;
            if (phase == 0) begin
                for (i = 0; i < N_DIRECTED; i++)
                    send_item(9'(dir_hue[i]), 7'(dir_sat[i]), 7'(dir_val[i]));
            end
            for (i = 0; i < RANDOM_ITEMS / 3; i++) begin
                // full-rate sender against a stalled receiver fills the pipe
                if (phase == 2 && i == 100)
                    hold_req++;
                send_item(9'($urandom_range(511)), rand_pct(), rand_pct());
            end
            // sender pauses until the pipe has fully drained
            wait_results_done();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items: sector edges, hue wrap, clamped percents, three idle",
                 items_sent);
        $display("profiles and a %0d-cycle output hold; %0d colors compared field by field",
                 HOLD_CYCLES, checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_sector.sv
hdl/hsvrgb_mix.sv
hdl/hsvrgb_out.sv
hdl/hsv_to_rgb_percent.sv
hdl/hsv_to_rgb_percent_chk.sv
bench/hsv_to_rgb_percent_checker.sv
bench/tb_hsv_to_rgb_percent.sv
